FILE: hw/rtl/lfa_pkg.sv
// Package for the lowest-free-id allocator: operation and status codes,
// controller states and the command/status structs between the two halves.
// Depends on nothing.
package lfa_pkg;

  // Operation codes carried by a request.
  typedef enum logic [2:0] {
    OP_ALLOC_NEXT = 3'd0,
    OP_ALLOC_AT   = 3'd1,
    OP_DUPLICATE  = 3'd2,
    OP_FREE       = 3'd3,
    OP_QUERY      = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // apply the operation to the table
    logic scan;  // test one slot of the free-slot search
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic need_scan;  // the lowest free slot was taken, a search must follow
    logic scan_hit;   // the search has settled the lowest free id
  } dp_sts_t;

endpackage

FILE: hw/rtl/lfa_ctrl.sv
// Controller for the lowest-free-id allocator: sequences capture, execution,
// the free-slot search and the result strobe.
// Depends on lfa_pkg.
module lfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lfa_pkg::dp_sts_t sts,
  output lfa_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             done
);
  import lfa_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lfa_datapath.sv
// Datapath for the lowest-free-id allocator: occupancy bitmap, item count,
// lowest free id, the search pointer and the result registers.
// Depends on lfa_pkg.
module lfa_datapath #(
  parameter int TABLE_SIZE = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  lfa_pkg::dp_cmd_t cmd,
  output lfa_pkg::dp_sts_t sts,
  input  logic [2:0]       op,
  input  logic [7:0]       id,
  output logic [2:0]       status,
  output logic [5:0]       used_id,
  output logic             occupied,
  output logic [6:0]       item_count,
  output logic [5:0]       next_free,
  output logic             is_full
);
  import lfa_pkg::*;

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);

  // Table state.
  logic [TABLE_SIZE-1:0] slot_used;
  logic [CW-1:0]         used_count;
  logic [IW-1:0]         lowest_free;
  logic [CW-1:0]         scan_ptr;

  // Captured request and result registers.
  op_t           op_q;
  logic [7:0]    id_q;
  status_t       status_q;
  logic [IW-1:0] used_q;
  logic          occ_next_q;

  logic          in_range;
  logic [IW-1:0] id_idx;
  logic          id_bit;
  logic          full;
  logic          empty;
  logic          scan_end;
  logic [IW-1:0] scan_idx;
  logic [8:0]    used_wide;
  logic [8:0]    count_wide;
  logic [8:0]    lowest_wide;

  assign in_range = {1'b0, id_q} < 9'(TABLE_SIZE);
  assign id_idx   = id_q[IW-1:0];
  assign id_bit   = in_range && slot_used[id_idx];
  assign full     = used_count == CW'(TABLE_SIZE);
  assign empty    = used_count == '0;
  assign scan_end = scan_ptr >= CW'(TABLE_SIZE);
  assign scan_idx = scan_ptr[IW-1:0];

  // Decide before execution whether the lowest free slot is about to be taken.
  always_comb begin
    sts.need_scan = 1'b0;
    case (op_q)
      OP_ALLOC_NEXT: sts.need_scan = !full;
      OP_ALLOC_AT:   sts.need_scan = !full && in_range && !slot_used[id_idx]
                                     && (id_idx == lowest_free);
      OP_DUPLICATE:  sts.need_scan = !full && id_bit;
      default:       sts.need_scan = 1'b0;
    endcase
    sts.scan_hit = scan_end || !slot_used[scan_idx];
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op_t'(op);
      id_q <= id;
    end
  end

  // Apply the operation, then walk upwards for the next free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      used_count  <= '0;
      lowest_free <= '0;
    end else if (cmd.exec) begin
      status_q   <= ST_OK;
      used_q     <= '0;
      occ_next_q <= 1'b0;
      scan_ptr   <= CW'(lowest_free) + CW'(1);
      case (op_q)
        OP_ALLOC_NEXT: begin
          if (full) begin
            status_q <= ST_FULL;
          end else begin
            slot_used[lowest_free] <= 1'b1;
            used_count             <= used_count + CW'(1);
            used_q                 <= lowest_free;
            occ_next_q             <= 1'b1;
          end
        end
        OP_ALLOC_AT: begin
          if (full) begin
            status_q <= ST_FULL;
          end else if (!in_range) begin
            status_q <= ST_RANGE;
          end else if (slot_used[id_idx]) begin
            status_q <= ST_EXISTS;
          end else begin
            slot_used[id_idx] <= 1'b1;
            used_count        <= used_count + CW'(1);
            used_q            <= id_idx;
          end
        end
        OP_DUPLICATE: begin
          if (full) begin
            status_q <= ST_FULL;
          end else if (!in_range) begin
            status_q <= ST_RANGE;
          end else if (!slot_used[id_idx]) begin
            status_q <= ST_MISSING;
          end else begin
            slot_used[lowest_free] <= 1'b1;
            used_count             <= used_count + CW'(1);
            used_q                 <= lowest_free;
          end
        end
        OP_FREE: begin
          if (empty) begin
            status_q <= ST_EMPTY;
          end else if (!in_range) begin
            status_q <= ST_RANGE;
          end else if (!slot_used[id_idx]) begin
            status_q <= ST_MISSING;
          end else begin
            slot_used[id_idx] <= 1'b0;
            used_count        <= used_count - CW'(1);
            used_q            <= id_idx;
            // A freed slot below the current lowest, or any freed slot of a full table, becomes the lowest.
            if (full || (id_idx < lowest_free)) begin
              lowest_free <= id_idx;
            end
          end
        end
        OP_QUERY: begin
          if (!in_range) begin
            status_q <= ST_RANGE;
          end
        end
        OP_CLEAR: begin
          slot_used   <= '0;
          used_count  <= '0;
          lowest_free <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.scan) begin
      // One slot a cycle; past the end the table is full and the id reads 0.
      if (scan_end) begin
        lowest_free <= '0;
      end else if (!slot_used[scan_idx]) begin
        lowest_free <= scan_idx;
      end else begin
        scan_ptr <= scan_ptr + CW'(1);
      end
    end
  end

  // Result fields, held stable from the end of execution and any search until the strobe.
  assign used_wide   = 9'(used_q);
  assign count_wide  = 9'(used_count);
  assign lowest_wide = full ? 9'd0 : 9'(lowest_free);

  always_comb begin
    occupied = occ_next_q;
    case (op_q)
      OP_ALLOC_AT, OP_DUPLICATE, OP_FREE, OP_QUERY: occupied = id_bit;
      default:                                      occupied = occ_next_q;
    endcase
  end

  assign status     = status_q;
  assign used_id    = used_wide[5:0];
  assign item_count = count_wide[6:0];
  assign next_free  = lowest_wide[5:0];
  assign is_full    = full;

endmodule

FILE: hw/rtl/lowest_free_id_allocator.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+-------------------------
// request   | op, id                                             | start high, busy low
// result    | status, used_id, occupied, item_count, next_free,  | done high for one cycle
//           | is_full                                            |
//
// A request is captured, executed and then answered with the done strobe; when it takes
// the lowest free slot, a search comes before the strobe: it walks the occupancy bitmap
// upwards one slot a cycle, starting just above the old lowest free id.
// Reset is synchronous and empties the table; clear does the same.
// busy stays high from acceptance to the done strobe; the receiver cannot stall.
// Holds the top level, which joins lfa_ctrl and lfa_datapath; uses lfa_pkg.
module lowest_free_id_allocator #(
  parameter int TABLE_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] id,
  output logic       done,
  output logic [2:0] status,
  output logic [5:0] used_id,
  output logic       occupied,
  output logic [6:0] item_count,
  output logic [5:0] next_free,
  output logic       is_full
);
  import lfa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  lfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Table and result registers.
  lfa_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (op),
    .id         (id),
    .status     (status),
    .used_id    (used_id),
    .occupied   (occupied),
    .item_count (item_count),
    .next_free  (next_free),
    .is_full    (is_full)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the lowest-free-id allocator: directed and random requests,
// with the results predicted by a scoreboard that keeps its own occupancy map.
// Depends on lfa_pkg and lowest_free_id_allocator.

module testbench;
  import lfa_pkg::*;

  localparam int TABLE_SIZE  = 64;
  localparam int ITEMS       = 1600;
  localparam int QUIET_ITEMS = 300;
  localparam int SETTLE      = TABLE_SIZE + 8;
  localparam int STALL_LIMIT = 3000;

  // Predicted response of one request.
  typedef struct {
    status_t    status;
    logic [5:0] used_id;
    logic       occupied;
    logic [6:0] item_count;
    logic [5:0] next_free;
    logic       is_full;
  } alloc_response_t;

  // Keeps a shadow occupancy map and the responses still owed by the block.
  class slot_scoreboard;
    bit              slot_map[TABLE_SIZE];
    int unsigned     count;
    int unsigned     lowest;
    alloc_response_t owed[$];
    int unsigned     mismatches;

    // The lowest free slot is found by a scan down to slot 0; it stays 0 while full.
    function void rescan();
      lowest = 0;
      for (int s = TABLE_SIZE - 1; s >= 0; s--) begin
        if (!slot_map[s]) lowest = s;
      end
    endfunction

    function void take(int unsigned s);
      slot_map[s] = 1'b1;
      count++;
      rescan();
    endfunction

    function void clear_table();
      foreach (slot_map[s]) slot_map[s] = 1'b0;
      count  = 0;
      lowest = 0;
    endfunction

    // Applies an accepted request to the shadow table and queues its response.
    function void note_request(logic [2:0] code, logic [7:0] slot);
      alloc_response_t r;
      bit in_range;
      bit full;
      in_range   = slot < TABLE_SIZE;
      full       = count >= TABLE_SIZE;
      r.status   = ST_OK;
      r.used_id  = '0;
      r.occupied = 1'b0;
      case (code)
        OP_ALLOC_NEXT: begin
          if (full) begin
            r.status = ST_FULL;
          end else begin
            r.used_id  = lowest[5:0];
            r.occupied = 1'b1;
            take(lowest);
          end
        end
        OP_ALLOC_AT: begin
          if (full) r.status = ST_FULL;
          else if (!in_range) r.status = ST_RANGE;
          else if (slot_map[slot]) r.status = ST_EXISTS;
          else begin
            r.used_id = slot[5:0];
            take(slot);
          end
        end
        OP_DUPLICATE: begin
          if (full) r.status = ST_FULL;
          else if (!in_range) r.status = ST_RANGE;
          else if (!slot_map[slot]) r.status = ST_MISSING;
          else begin
            r.used_id = lowest[5:0];
            take(lowest);
          end
        end
        OP_FREE: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (!in_range) r.status = ST_RANGE;
          else if (!slot_map[slot]) r.status = ST_MISSING;
          else begin
            slot_map[slot] = 1'b0;
            count--;
            r.used_id = slot[5:0];
            rescan();
          end
        end
        OP_QUERY: begin
          if (!in_range) r.status = ST_RANGE;
        end
        OP_CLEAR: clear_table();
        default: ;
      endcase
      // Ops that name a slot report its occupancy after the step.
      if (code >= OP_ALLOC_AT && code <= OP_QUERY && in_range) r.occupied = slot_map[slot];
      full         = count >= TABLE_SIZE;
      r.item_count = count[6:0];
      r.next_free  = full ? 6'd0 : lowest[5:0];
      r.is_full    = full;
      owed.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares a result from the block with the oldest response owed.
    function void check_result(logic [2:0] status, logic [5:0] used_id, logic occupied,
                               logic [6:0] item_count, logic [5:0] next_free, logic is_full);
      alloc_response_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: result with none expected, status actual %0d", $time, status);
        return;
      end
      want = owed.pop_front();
      if (status !== want.status) report("status", want.status, status);
      if (used_id !== want.used_id) report("used_id", want.used_id, used_id);
      if (occupied !== want.occupied) report("occupied", want.occupied, occupied);
      if (item_count !== want.item_count) report("item_count", want.item_count, item_count);
      if (next_free !== want.next_free) report("next_free", want.next_free, next_free);
      if (is_full !== want.is_full) report("is_full", want.is_full, is_full);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] op;
  logic [7:0] id;
  logic       done;
  logic [2:0] status;
  logic [5:0] used_id;
  logic       occupied;
  logic [6:0] item_count;
  logic [5:0] next_free;
  logic       is_full;

  slot_scoreboard sb = new();
  int unsigned items_sent;
  int unsigned quiet_cycles;

  lowest_free_id_allocator #(.TABLE_SIZE(TABLE_SIZE)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .id(id),
    .done(done), .status(status), .used_id(used_id), .occupied(occupied),
    .item_count(item_count), .next_free(next_free), .is_full(is_full)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Requests are noted as they are accepted; results are checked as they are strobed.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(op, id);
      if (done) sb.check_result(status, used_id, occupied, item_count, next_free, is_full);
    end
  end

  // Watchdog on cycles in which neither a request nor a result is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic [2:0] code, input logic [7:0] slot);
    @(negedge clk);
    start <= 1'b1;
    op    <= code;
    id    <= slot;
    do @(posedge clk); while (busy !== 1'b0);
    if (code <= OP_CLEAR) items_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Random idle bursts, left out in the closing part of the run.
  task automatic maybe_idle();
    if (items_sent < ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0)
      pause_sender($urandom_range(1, 11));
  endtask

  // Holds the sender off until every owed result has come, then lets the block settle.
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] any_id();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(TABLE_SIZE, 255));
    return 8'($urandom_range(0, TABLE_SIZE - 1));
  endfunction

  // Picks an occupied slot (or a free one) where there is one, else any slot.
  function automatic logic [7:0] pick_slot(input bit want_used);
    int unsigned picks[$];
    foreach (sb.slot_map[s]) if (sb.slot_map[s] == want_used) picks.push_back(s);
    if (picks.size() == 0) return 8'($urandom_range(0, TABLE_SIZE - 1));
    return 8'(picks[$urandom_range(0, picks.size() - 1)]);
  endfunction

  // One random request with a realistic mix of operations and slot ids.
  task automatic random_request();
    int unsigned pick;
    logic [7:0]  slot;
    pick = $urandom_range(0, 99);
    slot = ($urandom_range(0, 1) == 0) ? any_id() : pick_slot($urandom_range(0, 1));
    if (pick < 22) send_request(OP_ALLOC_NEXT, 8'($urandom()));
    else if (pick < 40) send_request(OP_ALLOC_AT, slot);
    else if (pick < 52) send_request(OP_DUPLICATE, slot);
    else if (pick < 76) send_request(OP_FREE, slot);
    else if (pick < 93) send_request(OP_QUERY, slot);
    else if (pick < 95) send_request(OP_CLEAR, 8'($urandom()));
    else send_request(3'($urandom_range(6, 7)), 8'($urandom()));
    maybe_idle();
  endtask

  // Fills the table, works on it while full, then reopens a few slots.
  task automatic fill_table();
    while (sb.count < TABLE_SIZE) begin
      case ($urandom_range(0, 2))
        0: send_request(OP_ALLOC_NEXT, 8'($urandom()));
        1: send_request(OP_DUPLICATE, pick_slot(1'b1));
        default: send_request(OP_ALLOC_AT, pick_slot(1'b0));
      endcase
      maybe_idle();
    end
    send_request(OP_ALLOC_NEXT, 8'd0);
    send_request(OP_ALLOC_AT, any_id());
    send_request(OP_DUPLICATE, any_id());
    repeat ($urandom_range(1, 6)) begin
      send_request(OP_FREE, pick_slot(1'b1));
      maybe_idle();
    end
  endtask

  // Empties the table slot by slot, then tries a few requests on the empty table.
  task automatic drain_table();
    while (sb.count > 0) begin
      if ($urandom_range(0, 4) == 0) send_request(OP_FREE, any_id());
      else send_request(OP_FREE, pick_slot(1'b1));
      maybe_idle();
    end
    send_request(OP_FREE, any_id());
    send_request(OP_QUERY, any_id());
    send_request(OP_DUPLICATE, any_id());
  endtask

  initial begin
    bit paused;
    rst        = 1'b1;
    start      = 1'b0;
    op         = OP_ALLOC_NEXT;
    id         = '0;
    items_sent = 0;
    paused     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, range checks, existing and missing slots, unused codes.
    send_request(OP_QUERY, 8'd0);
    send_request(OP_FREE, 8'd0);
    send_request(OP_FREE, 8'd255);
    send_request(OP_ALLOC_AT, 8'd255);
    send_request(OP_DUPLICATE, 8'd5);
    send_request(OP_DUPLICATE, 8'd64);
    send_request(OP_ALLOC_NEXT, 8'd0);
    send_request(OP_ALLOC_AT, 8'd63);
    send_request(OP_ALLOC_AT, 8'd63);
    send_request(OP_DUPLICATE, 8'd63);
    send_request(OP_QUERY, 8'd63);
    send_request(OP_QUERY, 8'd200);
    send_request(OP_FREE, 8'd0);
    send_request(OP_FREE, 8'd128);
    send_request(OP_FREE, 8'd10);
    send_request(3'd6, 8'hAA);
    send_request(3'd7, 8'h55);
    send_request(OP_ALLOC_AT, 8'd0);
    send_request(OP_CLEAR, 8'hFF);
    send_request(OP_QUERY, 8'd63);
    // A full table, and freeing from it, early on.
    fill_table();
    send_request(OP_FREE, 8'd0);
    send_request(OP_ALLOC_NEXT, 8'd0);

    // Random scenarios until enough requests have gone in.
    while (items_sent < ITEMS) begin
      case ($urandom_range(0, 9))
        6, 7: fill_table();
        8: drain_table();
        9: begin
          send_request(OP_CLEAR, 8'($urandom()));
          repeat ($urandom_range(5, 20)) random_request();
        end
        default: repeat ($urandom_range(10, 40)) random_request();
      endcase
      if (!paused && items_sent >= ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end

    wait_for_results();
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
